FILE: sv/gmp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid monotone path enumerator: shared package
// Widths, status and request codes, control word and flag types, the
// microprogram table and the row reachability helper.
// ----------------------------------------------------------------------------
package gmp_pkg;

  localparam int MAX_SIDE = 16;
  localparam int IDX_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = 5;
  localparam int MOVES_W  = 30;
  localparam int K_W      = 5;
  localparam int HALF     = MAX_SIDE / 2;
  localparam int UPC_W    = 4;

  localparam logic [SIDE_W-1:0] SIDE_MIN = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_W'(MAX_SIDE);

  localparam logic       REQ_LOAD   = 1'b0;
  localparam logic       REQ_FETCH  = 1'b1;
  localparam logic [1:0] ST_PATH    = 2'd0;
  localparam logic [1:0] ST_NO_MORE = 2'd1;
  localparam logic [1:0] ST_NO_PATH = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_BUILD_INIT,
    OP_BUILD_HI,
    OP_BUILD_LO,
    OP_FIRST,
    OP_BACK_INIT,
    OP_BACK_STEP,
    OP_CHECK,
    OP_TAKE,
    OP_COMPLETE,
    OP_EMIT_PATH,
    OP_EMIT_FAIL
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NO_FETCH,
    C_EXHAUSTED,
    C_REACH_OK,
    C_ROWS_LEFT,
    C_STARTED,
    C_NO_ORIGIN,
    C_BACK_AGAIN,
    C_NO_RIGHT,
    C_MORE_MOVES
  } cond_t;

  typedef struct packed {
    op_t              op;
    cond_t            cond;
    logic             hold;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_fetch;
    logic exhausted;
    logic reach_ok;
    logic rows_left;
    logic started;
    logic no_origin;
    logic back_again;
    logic no_right;
    logic more_moves;
    logic out_busy;
  } flags_t;

  // Microprogram addresses.
  localparam logic [UPC_W-1:0] UA_IDLE     = UPC_W'(0);
  localparam logic [UPC_W-1:0] UA_EXH      = UPC_W'(1);
  localparam logic [UPC_W-1:0] UA_BUILD    = UPC_W'(2);
  localparam logic [UPC_W-1:0] UA_BHI      = UPC_W'(3);
  localparam logic [UPC_W-1:0] UA_BLO      = UPC_W'(4);
  localparam logic [UPC_W-1:0] UA_START    = UPC_W'(5);
  localparam logic [UPC_W-1:0] UA_FIRST    = UPC_W'(6);
  localparam logic [UPC_W-1:0] UA_FIRST_GO = UPC_W'(7);
  localparam logic [UPC_W-1:0] UA_BACK     = UPC_W'(8);
  localparam logic [UPC_W-1:0] UA_BSTEP    = UPC_W'(9);
  localparam logic [UPC_W-1:0] UA_CHECK    = UPC_W'(10);
  localparam logic [UPC_W-1:0] UA_TAKE     = UPC_W'(11);
  localparam logic [UPC_W-1:0] UA_COMPL    = UPC_W'(12);
  localparam logic [UPC_W-1:0] UA_EMIT     = UPC_W'(13);
  localparam logic [UPC_W-1:0] UA_FAIL     = UPC_W'(14);

  // A word jumps to target when its condition holds, otherwise falls through.
  function automatic ctrl_t gmp_ucode(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: UA_IDLE};
    unique case (addr)
      UA_IDLE:     w = '{op: OP_IDLE,       cond: C_NO_FETCH,   hold: 1'b0, target: UA_IDLE};
      UA_EXH:      w = '{op: OP_NOP,        cond: C_EXHAUSTED,  hold: 1'b0, target: UA_FAIL};
      UA_BUILD:    w = '{op: OP_BUILD_INIT, cond: C_REACH_OK,   hold: 1'b0, target: UA_START};
      UA_BHI:      w = '{op: OP_BUILD_HI,   cond: C_NONE,       hold: 1'b0, target: UA_IDLE};
      UA_BLO:      w = '{op: OP_BUILD_LO,   cond: C_ROWS_LEFT,  hold: 1'b0, target: UA_BHI};
      UA_START:    w = '{op: OP_NOP,        cond: C_STARTED,    hold: 1'b0, target: UA_BACK};
      UA_FIRST:    w = '{op: OP_FIRST,      cond: C_NO_ORIGIN,  hold: 1'b0, target: UA_FAIL};
      UA_FIRST_GO: w = '{op: OP_NOP,        cond: C_ALWAYS,     hold: 1'b0, target: UA_COMPL};
      UA_BACK:     w = '{op: OP_BACK_INIT,  cond: C_NONE,       hold: 1'b0, target: UA_IDLE};
      UA_BSTEP:    w = '{op: OP_BACK_STEP,  cond: C_BACK_AGAIN, hold: 1'b0, target: UA_BSTEP};
      UA_CHECK:    w = '{op: OP_CHECK,      cond: C_NO_RIGHT,   hold: 1'b0, target: UA_FAIL};
      UA_TAKE:     w = '{op: OP_TAKE,       cond: C_NONE,       hold: 1'b0, target: UA_IDLE};
      UA_COMPL:    w = '{op: OP_COMPLETE,   cond: C_MORE_MOVES, hold: 1'b0, target: UA_COMPL};
      UA_EMIT:     w = '{op: OP_EMIT_PATH,  cond: C_ALWAYS,     hold: 1'b1, target: UA_IDLE};
      UA_FAIL:     w = '{op: OP_EMIT_FAIL,  cond: C_ALWAYS,     hold: 1'b1, target: UA_IDLE};
      default:     w = '{op: OP_NOP,        cond: C_ALWAYS,     hold: 1'b0, target: UA_IDLE};
    endcase
    return w;
  endfunction

  // Reachability across half a row, scanned from the right: a cell reaches
  // the corner when it is open and the cell below or to its right does.
  function automatic logic [HALF-1:0] gmp_chain(input logic [HALF-1:0] open_v,
                                                input logic [HALF-1:0] below_v,
                                                input logic            carry_in);
    logic [HALF-1:0] res;
    logic            cur;
    cur = carry_in;
    for (int i = HALF - 1; i >= 0; i--) begin
      cur    = open_v[i] & (below_v[i] | cur);
      res[i] = cur;
    end
    return res;
  endfunction

endpackage

FILE: sv/gmp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid monotone path enumerator: channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gmp_in_if import gmp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] cell_row;
  logic [IDX_W-1:0] cell_col;
  logic             cell_open;

  modport source (output valid, output req_type, output cell_row, output cell_col,
                  output cell_open, input ready);
  modport sink   (input valid, input req_type, input cell_row, input cell_col,
                  input cell_open, output ready);
endinterface

interface gmp_out_if import gmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [MOVES_W-1:0] path_moves;
  logic [K_W-1:0]     path_length;

  modport source (output valid, output status, output path_moves, output path_length,
                  input ready);
  modport sink   (input valid, input status, input path_moves, input path_length,
                  output ready);
endinterface

interface gmp_cfg_if import gmp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIDE_W-1:0] grid_size;

  modport source (output valid, output grid_size, input ready);
  modport sink   (input valid, input grid_size, output ready);
endinterface

FILE: sv/gmp_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid monotone path enumerator: microcode sequencer
// Step counter, microprogram lookup and conditional next-address logic.
// ----------------------------------------------------------------------------
module gmp_seq import gmp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  flags_t flags,
  output ctrl_t  ctrl
);

  logic [UPC_W-1:0] upc_r;
  logic [UPC_W-1:0] upc_nxt;
  logic             cond_hit;

  assign ctrl = gmp_ucode(upc_r);

  always_comb begin
    unique case (ctrl.cond)
      C_NONE:       cond_hit = 1'b0;
      C_ALWAYS:     cond_hit = 1'b1;
      C_NO_FETCH:   cond_hit = flags.no_fetch;
      C_EXHAUSTED:  cond_hit = flags.exhausted;
      C_REACH_OK:   cond_hit = flags.reach_ok;
      C_ROWS_LEFT:  cond_hit = flags.rows_left;
      C_STARTED:    cond_hit = flags.started;
      C_NO_ORIGIN:  cond_hit = flags.no_origin;
      C_BACK_AGAIN: cond_hit = flags.back_again;
      C_NO_RIGHT:   cond_hit = flags.no_right;
      C_MORE_MOVES: cond_hit = flags.more_moves;
      default:      cond_hit = 1'b0;
    endcase
  end

  // An emit word stays put while the output register is still occupied.
  always_comb begin
    priority if (ctrl.hold && flags.out_busy) begin
      upc_nxt = upc_r;
    end else if (cond_hit) begin
      upc_nxt = ctrl.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= UA_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

FILE: sv/gmp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid monotone path enumerator: datapath
// Grid and reachability rows, search position and path registers, the
// output register and the flags the sequencer branches on.
// ----------------------------------------------------------------------------
module gmp_datapath import gmp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  ctrl_t          ctrl,
  output flags_t         flags,
  gmp_in_if.sink         in_ch,
  gmp_out_if.source      out_ch,
  gmp_cfg_if.sink        cfg_ch
);

  logic [SIDE_W-1:0]   grid_size_r;
  logic [MAX_SIDE-1:0] grid_r  [MAX_SIDE];
  logic [MAX_SIDE-1:0] reach_r [MAX_SIDE];
  logic                started_r;
  logic                exhausted_r;
  logic                found_r;
  logic                reach_ok_r;
  logic                out_valid_r;
  logic [MOVES_W-1:0]  path_r;
  logic [K_W-1:0]      k_r;
  logic [IDX_W-1:0]    r_r;
  logic [IDX_W-1:0]    c_r;
  logic [IDX_W-1:0]    brow_r;
  logic [HALF-1:0]     hi_r;
  logic [1:0]          status_r;
  logic [MOVES_W-1:0]  moves_r;
  logic [K_W-1:0]      len_r;

  logic [SIDE_W-1:0]   n_w;
  logic [SIDE_W-1:0]   n_dec;
  logic [IDX_W-1:0]    n_m1;
  logic [SIDE_W:0]     two_n;
  logic [K_W-1:0]      m_w;
  logic                idle;
  logic                in_acc;
  logic                load_acc;
  logic                fetch_acc;
  logic                cfg_acc;
  logic                restart;
  logic                out_busy;
  logic                emit_go;

  logic [K_W-1:0]      uk;
  logic                ubit;
  logic [IDX_W-1:0]    ur;
  logic [IDX_W-1:0]    uc;
  logic                kbit;
  logic [K_W-1:0]      xk;
  logic [IDX_W-1:0]    xr;
  logic [IDX_W-1:0]    xc;
  logic                xbit;
  logic [SIDE_W-1:0]   xc1;
  logic [SIDE_W-1:0]   r1;
  logic [SIDE_W-1:0]   brow1;
  logic [IDX_W-1:0]    rd_addr;
  logic [MAX_SIDE-1:0] rd_row;
  logic                can_right;
  logic                go_down;

  logic [MAX_SIDE-1:0] colmask;
  logic [MAX_SIDE-1:0] open_m;
  logic [MAX_SIDE-1:0] below;
  logic [HALF-1:0]     hi_new;
  logic [HALF-1:0]     lo_new;

  // Side in use, clamped to the supported range.
  always_comb begin
    priority if (grid_size_r < SIDE_MIN) begin
      n_w = SIDE_MIN;
    end else if (grid_size_r > SIDE_MAX) begin
      n_w = SIDE_MAX;
    end else begin
      n_w = grid_size_r;
    end
  end

  assign n_dec = n_w - SIDE_W'(1);
  assign n_m1  = n_dec[IDX_W-1:0];
  assign two_n = {n_w, 1'b0};
  assign m_w   = K_W'(two_n - (SIDE_W + 1)'(2));

  assign idle      = (ctrl.op == OP_IDLE);
  assign in_acc    = in_ch.valid & in_ch.ready;
  assign load_acc  = in_acc & (in_ch.req_type == REQ_LOAD);
  assign fetch_acc = in_acc & (in_ch.req_type == REQ_FETCH);
  assign cfg_acc   = cfg_ch.valid & cfg_ch.ready;
  assign restart   = load_acc | cfg_acc;
  assign out_busy  = out_valid_r & ~out_ch.ready;
  assign emit_go   = ~restart & ~out_busy &
                     ((ctrl.op == OP_EMIT_PATH) | (ctrl.op == OP_EMIT_FAIL));

  assign in_ch.ready        = idle;
  assign cfg_ch.ready       = idle;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.path_moves  = moves_r;
  assign out_ch.path_length = len_r;

  // Stepping back over move k-1 recovers the position before that move.
  assign uk   = k_r - 1'b1;
  assign ubit = (uk < K_W'(MOVES_W)) ? path_r[uk] : 1'b0;
  assign ur   = ubit ? r_r : r_r - 1'b1;
  assign uc   = ubit ? c_r - 1'b1 : c_r;
  assign kbit = (k_r < K_W'(MOVES_W)) ? path_r[k_r] : 1'b0;

  assign xk   = (ctrl.op == OP_BACK_STEP) ? uk   : k_r;
  assign xr   = (ctrl.op == OP_BACK_STEP) ? ur   : r_r;
  assign xc   = (ctrl.op == OP_BACK_STEP) ? uc   : c_r;
  assign xbit = (ctrl.op == OP_BACK_STEP) ? ubit : kbit;

  assign xc1   = {1'b0, xc} + SIDE_W'(1);
  assign r1    = {1'b0, r_r} + SIDE_W'(1);
  assign brow1 = {1'b0, brow_r} + SIDE_W'(1);

  always_comb begin
    unique case (ctrl.op)
      OP_BUILD_HI, OP_BUILD_LO: rd_addr = brow1[IDX_W-1:0];
      OP_BACK_STEP, OP_CHECK:   rd_addr = xr;
      OP_COMPLETE:              rd_addr = r1[IDX_W-1:0];
      default:                  rd_addr = '0;
    endcase
  end

  assign rd_row    = reach_r[rd_addr];
  assign can_right = ~xbit & (xc1 < n_w) & rd_row[xc1[IDX_W-1:0]];
  assign go_down   = (r1 < n_w) & rd_row[c_r];

  // Row build: cells outside the active grid never count as open.
  always_comb begin
    for (int i = 0; i < MAX_SIDE; i++) begin
      colmask[i] = (SIDE_W'(i) < n_w);
    end
  end

  assign open_m = grid_r[brow_r] & colmask;
  assign below  = (brow_r == n_m1) ? (MAX_SIDE'(1) << n_m1) : rd_row;
  assign hi_new = gmp_chain(open_m[MAX_SIDE-1:HALF], below[MAX_SIDE-1:HALF], 1'b0);
  assign lo_new = gmp_chain(open_m[HALF-1:0], below[HALF-1:0], hi_r[0]);

  assign flags.no_fetch   = ~fetch_acc;
  assign flags.exhausted  = exhausted_r;
  assign flags.reach_ok   = reach_ok_r;
  assign flags.rows_left  = (brow_r != '0);
  assign flags.started    = started_r;
  assign flags.no_origin  = ~rd_row[0];
  assign flags.back_again = ~can_right & (xk != '0);
  assign flags.no_right   = ~can_right;
  assign flags.more_moves = (k_r != m_w) & (K_W'(k_r + 1'b1) != m_w);
  assign flags.out_busy   = out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= SIDE_MIN;
      started_r   <= 1'b0;
      exhausted_r <= 1'b0;
      found_r     <= 1'b0;
      reach_ok_r  <= 1'b0;
      out_valid_r <= 1'b0;
      path_r      <= '0;
    end else begin
      // A new result loaded in the same cycle keeps the register full.
      if (out_ch.valid && out_ch.ready && !emit_go) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_acc) begin
        grid_size_r <= cfg_ch.grid_size;
      end
      if (restart) begin
        started_r   <= 1'b0;
        exhausted_r <= 1'b0;
        found_r     <= 1'b0;
        reach_ok_r  <= 1'b0;
        path_r      <= '0;
      end else begin
        unique case (ctrl.op)
          OP_BUILD_LO: begin
            if (brow_r == '0) reach_ok_r <= 1'b1;
          end
          OP_FIRST: begin
            started_r <= 1'b1;
            path_r    <= '0;
          end
          OP_TAKE: begin
            path_r[k_r] <= 1'b1;
          end
          OP_COMPLETE: begin
            if (k_r != m_w) path_r[k_r] <= ~go_down;
          end
          OP_EMIT_PATH: begin
            if (!out_busy) begin
              out_valid_r <= 1'b1;
              found_r     <= 1'b1;
            end
          end
          OP_EMIT_FAIL: begin
            if (!out_busy) begin
              out_valid_r <= 1'b1;
              exhausted_r <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      grid_r[in_ch.cell_row][in_ch.cell_col] <= in_ch.cell_open;
    end
    unique case (ctrl.op)
      OP_BUILD_INIT: begin
        brow_r <= n_m1;
      end
      OP_BUILD_HI: begin
        hi_r <= hi_new;
      end
      OP_BUILD_LO: begin
        reach_r[brow_r] <= {hi_r, lo_new};
        brow_r          <= brow_r - 1'b1;
      end
      OP_FIRST: begin
        k_r <= '0;
        r_r <= '0;
        c_r <= '0;
      end
      OP_BACK_INIT: begin
        k_r <= m_w;
        r_r <= n_m1;
        c_r <= n_m1;
      end
      OP_BACK_STEP: begin
        k_r <= uk;
        r_r <= ur;
        c_r <= uc;
      end
      OP_TAKE: begin
        c_r <= c_r + 1'b1;
        k_r <= k_r + 1'b1;
      end
      OP_COMPLETE: begin
        if (k_r != m_w) begin
          if (go_down) begin
            r_r <= r_r + 1'b1;
          end else begin
            c_r <= c_r + 1'b1;
          end
          k_r <= k_r + 1'b1;
        end
      end
      OP_EMIT_PATH: begin
        if (!out_busy) begin
          status_r <= ST_PATH;
          moves_r  <= path_r;
          len_r    <= m_w;
        end
      end
      OP_EMIT_FAIL: begin
        if (!out_busy) begin
          status_r <= found_r ? ST_NO_MORE : ST_NO_PATH;
          moves_r  <= '0;
          len_r    <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: sv/grid_monotone_path_enumerator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid monotone path enumerator: top level
// Loads a square grid cell by cell and hands out its down/right paths from
// corner to corner in lexicographic order, one per fetch request.
//
//   channel  dir  payload                                   transaction
//   in_ch    in   req_type, cell_row, cell_col, cell_open   load or fetch
//   out_ch   out  status, path_moves, path_length           one per fetch
//   cfg_ch   in   grid_size                                 register write
//
// A load writes one cell. The first fetch after a load or write builds the
// reachability rows and completes the first path one move a cycle. Later
// fetches step back and complete one move a cycle each. Requests and writes
// are taken only while the sequencer is idle. A finished result waits in the
// output register while the next request is taken. Reset is synchronous and
// clears control state; no clearing pass.
// ----------------------------------------------------------------------------
module grid_monotone_path_enumerator import gmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gmp_in_if.sink    in_ch,
  gmp_out_if.source out_ch,
  gmp_cfg_if.sink   cfg_ch
);

  ctrl_t  ctrl;
  flags_t flags;

  gmp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  gmp_datapath u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .flags  (flags),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

`ifndef ASSERT_OFF
  // An accepted fetch always starts the microprogram.
  a_fetch_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.req_type == REQ_FETCH) |=> (ctrl.op != OP_IDLE))
    else $error("fetch transaction did not start the sequencer");

  // A path result waits while the output register is still taken.
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_EMIT_PATH && out_ch.valid && !out_ch.ready) |=> (ctrl.op == OP_EMIT_PATH))
    else $error("path result left the emit step while output was stalled");

  // Results without a path carry no moves.
  a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_PATH)
      |-> (out_ch.path_moves == '0 && out_ch.path_length == '0))
    else $error("no-path result carries move data");
`endif

endmodule
